### design/gaussian_blur_5x5_rgb_defines.svh
// Assertion macros shared by the blur block.
`ifndef GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GB5_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GB5_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication, held off during reset.
`define GB5_ASSERT_AFTER3(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

### design/gb5_pkg.sv
// Shared types, constants and weight helpers for the 5x5 blur.
package gb5_pkg;

    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned ROW_W      = 12;
    localparam int unsigned ITEMS_W    = 23;
    localparam int unsigned TAPS       = 5;

    localparam logic [10:0]        FRAME_WIDTH_RST  = 11'd640;
    localparam logic [12:0]        FRAME_HEIGHT_RST = 13'd480;
    localparam logic [ITEMS_W-1:0] ITEMS_LIMIT      = '1;

    localparam logic [2:0] TAP_WEIGHT [TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_PTR_W = 3;
    localparam int unsigned FIFO_CNT_W = 4;
    localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [11:0] r;
        logic [11:0] g;
        logic [11:0] b;
    } rgb_sum_t;

    typedef struct packed {
        logic       valid;
        logic       emit;
        logic       last;
        logic [4:0] row_mask;
        logic [4:0] col_mask;
    } item_tag_t;

    typedef struct packed {
        logic       rd_en;
        logic       shift_en;
        logic [4:0] col_mask;
    } cell_ctrl_t;

    typedef struct packed {
        rgb_t pix;
        logic last;
    } out_item_t;

    // horizontal tap: 8-bit component times its weight
    function automatic logic [11:0] tap_mul(input logic [7:0] v, input logic [2:0] idx);
        return 12'(v) * 12'(TAP_WEIGHT[idx]);
    endfunction

    // vertical tap: row sum times its row weight
    function automatic logic [15:0] row_mul(input logic [11:0] v, input logic [2:0] idx);
        return 16'(v) * 16'(TAP_WEIGHT[idx]);
    endfunction

endpackage

### design/gb5_line_cell.sv
// One window row: optional line memory, five taps and the masked row sum.
module gb5_line_cell #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter bit          HAS_LINE  = 1'b1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gb5_pkg::cell_ctrl_t          ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  gb5_pkg::rgb_t                pix_in,
    output gb5_pkg::rgb_t                col_out,
    output gb5_pkg::rgb_sum_t            row_sum
);

    gb5_pkg::rgb_t     taps_reg [gb5_pkg::TAPS];
    gb5_pkg::rgb_sum_t row_sum_reg;
    gb5_pkg::rgb_sum_t row_sum_next;

    generate
        if (HAS_LINE) begin : g_line
            gb5_pkg::rgb_t line_mem [MAX_WIDTH];
            gb5_pkg::rgb_t rd_data_reg;
            gb5_pkg::rgb_t fwd_data_reg;
            logic          fwd_reg;

            // read old column, store the one handed down from the row below
            always_ff @(posedge clk)
            begin
                if (ctrl.rd_en)
                begin
                    rd_data_reg  <= line_mem[rd_addr];
                    fwd_data_reg <= pix_in;
                end
                if (ctrl.shift_en)
                begin
                    line_mem[wr_addr] <= pix_in;
                end
            end

            // read colliding with the write of the item ahead
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    fwd_reg <= 1'b0;
                end
                else if (ctrl.rd_en)
                begin
                    fwd_reg <= ctrl.shift_en && (rd_addr == wr_addr);
                end
            end

            assign col_out = fwd_reg ? fwd_data_reg : rd_data_reg;
        end
        else begin : g_feed
            assign col_out = pix_in;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            for (int j = 0; j < gb5_pkg::TAPS - 1; j++)
            begin
                taps_reg[j] <= taps_reg[j+1];
            end
            taps_reg[gb5_pkg::TAPS-1] <= col_out;
        end
    end

    always_comb
    begin
        row_sum_next = '0;
        for (int j = 0; j < gb5_pkg::TAPS; j++)
        begin
            if (ctrl.col_mask[j])
            begin
                row_sum_next.r = row_sum_next.r + gb5_pkg::tap_mul(taps_reg[j].r, 3'(j));
                row_sum_next.g = row_sum_next.g + gb5_pkg::tap_mul(taps_reg[j].g, 3'(j));
                row_sum_next.b = row_sum_next.b + gb5_pkg::tap_mul(taps_reg[j].b, 3'(j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum_next;
    end

    assign row_sum = row_sum_reg;

endmodule

### design/gb5_out_fifo.sv
// Result queue between the filter pipeline and the output stream.
module gb5_out_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  gb5_pkg::out_item_t                 push_data,
    input  logic                               pop,
    output gb5_pkg::out_item_t                 pop_data,
    output logic [gb5_pkg::FIFO_CNT_W-1:0]     count
);

    gb5_pkg::out_item_t                entry_reg [gb5_pkg::FIFO_DEPTH];
    logic [gb5_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [gb5_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [gb5_pkg::FIFO_CNT_W-1:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

### design/gaussian_blur_5x5_rgb.sv
// Top level of the 5x5 binomial Gaussian blur for a raster RGB pixel stream.
// The block takes one transaction per clock and gives one result per clock in
// steady state while the receiver keeps up. Each slave transaction is a pixel
// (tuser low) or a flush (tuser high, treated as a black pixel inside the
// frame). The result for frame pixel p leaves on the master side once
// transaction p+2*W+2 of the frame has been taken (W = effective width); after
// the last pixel the host sends 2*W+2 flush transactions to drain the frame.
// Inside the block a result passes the registered line memory read, the window
// shift and the row sums, then the column sum goes straight into the queue.
// Throughput is set by the single read and write port of each line memory, one
// column per clock. Taps outside the frame are dropped and not renormalised, so
// the border comes out darker. Line memories are not cleared after reset; their
// stale contents only ever reach masked taps. Width and height are written
// through the cfg port while the block is idle, a rule for the host that the
// block does not enforce; width 0 acts as 1, widths above MAX_WIDTH act as
// MAX_WIDTH (written widths keep bits 10:0), likewise height against 4096.
`include "gaussian_blur_5x5_rgb_defines.svh"

module gaussian_blur_5x5_rgb #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic        s_tuser,   // mode: 0 pixel, 1 flush
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic        m_tlast    // frame_end
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    // configuration
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;

    // frame position counters
    logic [gb5_pkg::ITEMS_W-1:0] items_seen_reg, items_seen_next;
    logic [gb5_pkg::ROW_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]            out_col_reg, out_col_next;
    logic [COL_W-1:0]            in_col_reg, in_col_next;

    // decoded sizes and per-item decisions
    logic [15:0] eff_w16;
    logic [15:0] eff_h16;
    logic [15:0] row16;
    logic [15:0] col16;
    logic [15:0] icol16;
    logic [16:0] emit_thresh;
    logic        emit;
    logic        last;
    logic [4:0]  row_mask;
    logic [4:0]  col_mask;
    logic [gb5_pkg::ITEMS_W-1:0] items_inc;
    logic        s_acc;
    logic        m_acc;

    // pipeline: s1 = line read returned, s2 = window shifted, s3 = row sums
    gb5_pkg::item_tag_t s1_tag_reg;
    gb5_pkg::item_tag_t s2_tag_reg;
    gb5_pkg::item_tag_t s3_tag_reg;
    logic [COL_W-1:0]   s1_col_reg;
    gb5_pkg::rgb_t      s1_pix_reg;
    gb5_pkg::rgb_t      in_pix;
    logic [1:0]         inflight;

    // cell chain
    gb5_pkg::cell_ctrl_t cell_ctrl;
    gb5_pkg::rgb_t       col_link [gb5_pkg::TAPS+1];
    gb5_pkg::rgb_sum_t   row_sums [gb5_pkg::TAPS];

    // column sum and output queue
    logic [15:0]                     sum_r, sum_g, sum_b;
    logic                            push;
    gb5_pkg::out_item_t              push_data;
    gb5_pkg::out_item_t              pop_data;
    logic [gb5_pkg::FIFO_CNT_W-1:0]  fifo_count;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gb5_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= gb5_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gb5_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[10:0];
                gb5_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
            endcase
        end
    end

    // effective sizes, clamped into range
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w16 = 16'd1;
        end
        else if (16'(frame_width_reg) > 16'(MAX_WIDTH))
        begin
            eff_w16 = 16'(MAX_WIDTH);
        end
        else
        begin
            eff_w16 = 16'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            eff_h16 = 16'd1;
        end
        else if (16'(frame_height_reg) > 16'(gb5_pkg::MAX_HEIGHT))
        begin
            eff_h16 = 16'(gb5_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h16 = 16'(frame_height_reg);
        end
    end

    // ------------------------------------------------- per-transaction decode
    assign row16       = 16'(out_row_reg);
    assign col16       = 16'(out_col_reg);
    assign icol16      = 16'(in_col_reg);
    assign emit_thresh = {eff_w16, 1'b0} + 17'd2;
    // a result is due once the window holds two rows and two pixels past it
    assign emit        = items_seen_reg >= gb5_pkg::ITEMS_W'(emit_thresh);
    assign last        = ((row16 + 16'd1) >= eff_h16) && ((col16 + 16'd1) >= eff_w16);
    assign items_inc   = (items_seen_reg == gb5_pkg::ITEMS_LIMIT) ?
                         items_seen_reg : items_seen_reg + 1'b1;

    // rows and columns of the window that fall inside the frame
    assign row_mask[0] = row16 >= 16'd2;
    assign row_mask[1] = row16 >= 16'd1;
    assign row_mask[2] = row16 < eff_h16;
    assign row_mask[3] = (row16 + 16'd1) < eff_h16;
    assign row_mask[4] = (row16 + 16'd2) < eff_h16;
    assign col_mask[0] = col16 >= 16'd2;
    assign col_mask[1] = col16 >= 16'd1;
    assign col_mask[2] = col16 < eff_w16;
    assign col_mask[3] = (col16 + 16'd1) < eff_w16;
    assign col_mask[4] = (col16 + 16'd2) < eff_w16;

    // flush transactions enter as black pixels
    always_comb
    begin
        if (s_tuser)
        begin
            in_pix = '0;
        end
        else
        begin
            in_pix.r = s_tdata[7:0];
            in_pix.g = s_tdata[15:8];
            in_pix.b = s_tdata[23:16];
        end
    end

    always_comb
    begin
        items_seen_next = items_seen_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        in_col_next     = in_col_reg;
        if (s_acc)
        begin
            in_col_next     = ((icol16 + 16'd1) >= eff_w16) ? '0 : in_col_reg + 1'b1;
            items_seen_next = items_inc;
            if (emit)
            begin
                if (last)
                begin
                    // frame done: every counter back to pixel 0
                    items_seen_next = '0;
                    out_row_next    = '0;
                    out_col_next    = '0;
                    in_col_next     = '0;
                end
                else if ((col16 + 16'd1) >= eff_w16)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_seen_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            in_col_reg     <= '0;
        end
        else
        begin
            items_seen_reg <= items_seen_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            in_col_reg     <= in_col_next;
        end
    end

    // ----------------------------------------------------------- pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg.valid    <= s_acc;
            s1_tag_reg.emit     <= s_acc && emit;
            s1_tag_reg.last     <= last;
            s1_tag_reg.row_mask <= row_mask;
            s1_tag_reg.col_mask <= col_mask;
            s2_tag_reg          <= s1_tag_reg;
            s3_tag_reg          <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_col_reg <= in_col_reg;
            s1_pix_reg <= in_pix;
        end
    end

    // ready keeps room in the queue for every result still in the pipeline
    assign inflight = 2'(s1_tag_reg.emit) + 2'(s2_tag_reg.emit) + 2'(s3_tag_reg.emit);
    assign s_tready = (5'(fifo_count) + 5'(inflight)) < 5'(gb5_pkg::FIFO_DEPTH);

    // ---------------------------------------------------------- cell chain
    // New pixel enters at the bottom cell; each line cell hands its stored
    // column up to the row above while taking the one from below.
    assign cell_ctrl.rd_en    = s_acc;
    assign cell_ctrl.shift_en = s1_tag_reg.valid;
    assign cell_ctrl.col_mask = s2_tag_reg.col_mask;
    assign col_link[gb5_pkg::TAPS] = s1_pix_reg;

    generate
        for (genvar k = 0; k < gb5_pkg::TAPS; k++)
        begin : g_cell
            gb5_line_cell #(
                .MAX_WIDTH (MAX_WIDTH),
                .HAS_LINE  (k < gb5_pkg::TAPS - 1)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl),
                .rd_addr (in_col_reg),
                .wr_addr (s1_col_reg),
                .pix_in  (col_link[k+1]),
                .col_out (col_link[k]),
                .row_sum (row_sums[k])
            );
        end
    endgenerate

    // --------------------------------------------------------- column sum
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < gb5_pkg::TAPS; k++)
        begin
            if (s3_tag_reg.row_mask[k])
            begin
                sum_r = sum_r + gb5_pkg::row_mul(row_sums[k].r, 3'(k));
                sum_g = sum_g + gb5_pkg::row_mul(row_sums[k].g, 3'(k));
                sum_b = sum_b + gb5_pkg::row_mul(row_sums[k].b, 3'(k));
            end
        end
    end

    // divide by 256, remainder dropped
    assign push            = s3_tag_reg.emit;
    assign push_data.pix.r = sum_r[15:8];
    assign push_data.pix.g = sum_g[15:8];
    assign push_data.pix.b = sum_b[15:8];
    assign push_data.last  = s3_tag_reg.last;

    gb5_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (m_acc),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign m_tvalid = fifo_count != '0;
    assign m_tdata  = {pop_data.pix.b, pop_data.pix.g, pop_data.pix.r};
    assign m_tlast  = pop_data.last;

    // ---------------------------------------------------------- assertions
    `GB5_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, fifo_count != gb5_pkg::FIFO_FULL, "result pushed into a full queue")
    `GB5_ASSERT_NEXT(a_frame_wrap, clk, rst_n, s_acc && emit && last, (items_seen_reg == '0) && (in_col_reg == '0), "counters not cleared after frame end")
    `GB5_ASSERT_AFTER3(a_result_latency, clk, rst_n, s_acc && emit, push, "due result did not reach the queue")

endmodule

### verif/gaussian_blur_5x5_rgb_checker.sv
// Checker for the 5x5 blur: watches the ports, predicts each filtered pixel and compares.
module gaussian_blur_5x5_rgb_checker #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic        s_tuser,   // mode: 0 pixel, 1 flush
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    input  logic        m_tlast,   // frame_end
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned KERNEL_ROW [5] = '{1, 4, 6, 4, 1};
    localparam int          REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } blurred_px_t;

    logic [10:0]   width_reg;
    logic [12:0]   height_reg;
    gb5_pkg::rgb_t line_mem [4][MAX_WIDTH];
    gb5_pkg::rgb_t taps [5][5];
    int unsigned   items_seen;
    int unsigned   out_row;
    int unsigned   out_col;
    int unsigned   in_col;
    int            mismatches;
    blurred_px_t   expected_pixels [$];

    // one slave transaction through the line stores and window
    task automatic filter_next_item(input logic is_flush, input gb5_pkg::rgb_t px,
                                    output bit emitted, output blurred_px_t res);
        int unsigned   w;
        int unsigned   h;
        int unsigned   col;
        int unsigned   wt;
        int unsigned   sum_r;
        int unsigned   sum_g;
        int unsigned   sum_b;
        int            rr;
        int            cc;
        bit            last;
        gb5_pkg::rgb_t column [5];
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 :
            (height_reg > gb5_pkg::MAX_HEIGHT) ? gb5_pkg::MAX_HEIGHT : height_reg;
        col = (in_col < MAX_WIDTH) ? in_col : 0;
        emitted = 1'b0;
        res = '0;

        for (int k = 0; k < 4; k++)
            column[k] = line_mem[k][col];
        column[4] = is_flush ? gb5_pkg::rgb_t'('0) : px;
        for (int k = 0; k < 4; k++)
            line_mem[k][col] = column[k + 1];

        for (int k = 0; k < 5; k++)
        begin
            for (int j = 0; j < 4; j++)
                taps[k][j] = taps[k][j + 1];
            taps[k][4] = column[k];
        end

        in_col++;
        if (in_col >= w)
            in_col = 0;

        if (items_seen >= 2 * w + 2)
        begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            for (int k = 0; k < 5; k++)
            begin
                rr = int'(out_row) + k - 2;
                if (rr < 0 || rr >= int'(h))
                    continue;
                for (int j = 0; j < 5; j++)
                begin
                    cc = int'(out_col) + j - 2;
                    if (cc < 0 || cc >= int'(w))
                        continue;
                    wt = KERNEL_ROW[k] * KERNEL_ROW[j];
                    sum_r += wt * taps[k][j].r;
                    sum_g += wt * taps[k][j].g;
                    sum_b += wt * taps[k][j].b;
                end
            end
            res.red       = 8'(sum_r >> 8);
            res.green     = 8'(sum_g >> 8);
            res.blue      = 8'(sum_b >> 8);
            res.frame_end = last;
            emitted       = 1'b1;
            if (last)
            begin
                items_seen = 0;
                out_row    = 0;
                out_col    = 0;
                in_col     = 0;
            end
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
                if (items_seen < gb5_pkg::ITEMS_LIMIT)
                    items_seen++;
            end
        end
        else if (items_seen < gb5_pkg::ITEMS_LIMIT)
        begin
            items_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit          emitted;
        blurred_px_t next_px;
        blurred_px_t got;
        blurred_px_t want;
        if (!rst_n)
        begin
            width_reg  = gb5_pkg::FRAME_WIDTH_RST;
            height_reg = gb5_pkg::FRAME_HEIGHT_RST;
            for (int k = 0; k < 4; k++)
                for (int c = 0; c < MAX_WIDTH; c++)
                    line_mem[k][c] = '0;
            for (int k = 0; k < 5; k++)
                for (int j = 0; j < 5; j++)
                    taps[k][j] = '0;
            items_seen = 0;
            out_row    = 0;
            out_col    = 0;
            in_col     = 0;
            mismatches = 0;
            expected_pixels.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == gb5_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_wdata[10:0];
                else
                    height_reg = cfg_wdata;
            end

            if (s_tvalid && s_tready)
            begin
                filter_next_item(s_tuser,
                                 '{r: s_tdata[7:0], g: s_tdata[15:8], b: s_tdata[23:16]},
                                 emitted, next_px);
                if (emitted)
                    expected_pixels.push_back(next_px);
            end

            if (m_tvalid && m_tready)
            begin
                got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16],
                        frame_end: m_tlast};
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result r=%h g=%h b=%h last=%b", $time,
                                 got.red, got.green, got.blue, got.frame_end);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: mismatch: expected r=%h g=%h b=%h last=%b, ",
                                      "got r=%h g=%h b=%h last=%b"}, $time,
                                     want.red, want.green, want.blue, want.frame_end,
                                     got.red, got.green, got.blue, got.frame_end);
                    end
                end
            end

            errors  <= mismatches;
            pending <= expected_pixels.size();
        end
    end

endmodule

### verif/gaussian_blur_5x5_rgb_test.sv
// Top of the 5x5 blur testbench: clock, reset, frame stimulus, idling and the verdict.
module gaussian_blur_5x5_rgb_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_WIDTH    = 1024;
    localparam int unsigned RANDOM_ITEMS = 1750;
    // generous ceiling for ~1.8k transactions, taken well over
    localparam int unsigned TIMEOUT_NS   = 5_000_000;
    // settle time past the pipeline registers and the output queue
    localparam int unsigned DRAIN_CYCLES = 16;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // width/height register values for a few wider or taller frames
    localparam int unsigned BIG_W [4] = '{64, 1, 100, 2};
    localparam int unsigned BIG_H [4] = '{1, 64, 2, 40};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // red_in[7:0], green_in[15:8], blue_in[23:16]
    logic        s_tuser   = 1'b0;   // mode: 0 pixel, 1 flush
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic        m_tlast;            // frame_end

    int blur_errors;
    int blur_pending;

    // idling odds in percent, changed as the run moves through its phases
    int send_idle_pct = 33;
    int recv_idle_pct = 59;

    gaussian_blur_5x5_rgb #(.MAX_WIDTH(MAX_WIDTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    gaussian_blur_5x5_rgb_checker #(.MAX_WIDTH(MAX_WIDTH)) blur_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (blur_errors),
        .pending   (blur_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver stalls at random; at 0 % it takes every result
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned limit);
        return (v == 0) ? 1 : (v > limit) ? limit : v;
    endfunction

    // colour level biased towards black and full scale
    function automatic logic [7:0] rand_level();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one slave transaction, with random idle cycles in front of it;
    // tvalid stays high on return so back-to-back transactions need no gap
    task automatic push_item(input logic mode, input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {blue, green, red};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending, wait for every predicted result, then let the pipeline settle
    task automatic drain_block();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (blur_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // width then height on consecutive edges, only while the block is idle
    task automatic set_frame_size(input logic [12:0] width_val, input logic [12:0] height_val);
        cfg_we    <= 1'b1;
        cfg_index <= gb5_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= width_val;
        @(posedge clk);
        cfg_index <= gb5_pkg::REG_FRAME_HEIGHT;
        cfg_wdata <= height_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A full frame: W*H transactions with the odd flush inside the frame
    // (taken as black), then the 2W+2 trailing transactions, mostly flushes but
    // some pixels, which land only in masked taps.
    task automatic run_frame(input int unsigned width_val, input int unsigned height_val,
                             input bit resize, output int unsigned sent);
        int unsigned w;
        int unsigned h;
        w = clamp_size(width_val, MAX_WIDTH);
        h = clamp_size(height_val, gb5_pkg::MAX_HEIGHT);
        if (resize)
        begin
            drain_block();
            set_frame_size(13'(width_val), 13'(height_val));
        end
        for (int unsigned i = 0; i < w * h; i++)
            push_item(($urandom_range(99) < 6) ? MODE_FLUSH : MODE_PIXEL,
                      rand_level(), rand_level(), rand_level());
        for (int unsigned i = 0; i < 2 * w + 2; i++)
            push_item(($urandom_range(99) < 25) ? MODE_PIXEL : MODE_FLUSH,
                      rand_level(), rand_level(), rand_level());
        sent = w * h + 2 * w + 2;
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned sent;
        int unsigned cur_w;
        int unsigned cur_h;
        int unsigned next_w;
        int unsigned next_h;
        int          frame_no;
        int          big_no;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: 3x2 frame with extreme levels ---
        set_frame_size(13'd3, 13'd2);
        push_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
        push_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        // flush inside the frame carries white data but must count as black
        push_item(MODE_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        push_item(MODE_PIXEL, 8'hFF, 8'h00, 8'h80);
        push_item(MODE_PIXEL, 8'h01, 8'h7F, 8'hFE);
        push_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        // trailing part: pixels past the frame end must act as flushes
        for (int i = 0; i < 8; i++)
            push_item(i[0] ? MODE_PIXEL : MODE_FLUSH, 8'hFF, 8'hFF, 8'hFF);

        // zero width and height behave as a 1x1 frame
        drain_block();
        set_frame_size(13'd0, 13'd0);
        push_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 4; i++)
            push_item(MODE_FLUSH, 8'hAA, 8'h55, 8'hAA);
        cur_w = 0;
        cur_h = 0;

        // --- random frames, mostly small, a few wider or taller ones ---
        random_items = 0;
        frame_no     = 0;
        big_no       = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            // idling phases: sender-light, then receiver-light, then none
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 59;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (frame_no > 0 && frame_no % 3 == 0 && big_no < 4)
            begin
                run_frame(BIG_W[big_no], BIG_H[big_no], 1'b1, sent);
                cur_w = BIG_W[big_no];
                cur_h = BIG_H[big_no];
                big_no++;
            end
            else
            begin
                next_w = cur_w;
                next_h = cur_h;
                // keep the size for some frames so frames run back to back
                if ($urandom_range(99) < 70 || cur_w > 40 || cur_h > 16)
                begin
                    case ($urandom_range(19))
                        0:       next_w = 0;
                        1:       next_w = $urandom_range(40, 13);
                        default: next_w = $urandom_range(12, 1);
                    endcase
                    case ($urandom_range(19))
                        0:       next_h = 0;
                        1:       next_h = $urandom_range(16, 7);
                        default: next_h = $urandom_range(6, 1);
                    endcase
                end
                run_frame(next_w, next_h, (next_w != cur_w) || (next_h != cur_h), sent);
                cur_w = next_w;
                cur_h = next_h;
            end
            random_items += sent;
            frame_no++;
        end

        drain_block();
        if (blur_errors == 0 && blur_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
